// ----- rtl/bc1e_pkg.sv -----
// ----------------------------------------------------------------------------
// bc1e_pkg
// shared types, constants and color helpers for the bc1 index encoder
// ----------------------------------------------------------------------------
package bc1e_pkg;

    localparam int unsigned PixelW      = 24;
    localparam int unsigned ColorW      = 16;
    localparam int unsigned IndexW      = 32;
    localparam int unsigned PosW        = 4;
    localparam int unsigned ErrW        = 18;
    // floor(x / 3) == (x * Recip3) >> Recip3Shift for every x up to 765
    localparam int unsigned Recip3      = 683;
    localparam int unsigned Recip3Shift = 11;

    typedef logic [7:0]          chan_t;
    typedef logic [ColorW-1:0]   color565_t;
    typedef logic [ErrW-1:0]     err_t;
    typedef logic [1:0]          idx_t;
    typedef logic [PosW-1:0]     pos_t;

    // red sits in the low byte, blue in the high byte
    typedef struct packed {
        chan_t b;
        chan_t g;
        chan_t r;
    } rgb_t;

    typedef rgb_t [3:0] palette_t;
    typedef err_t [3:0] err_set_t;

    // rgb565 to rgb888 by bit replication
    function automatic rgb_t expand565(color565_t c);
        rgb_t res;
        res.r = {c[15:11], c[15:13]};
        res.g = {c[10:5], c[10:9]};
        res.b = {c[4:0], c[4:2]};
        return res;
    endfunction

    // truncating divide by three for sums of up to 765
    function automatic chan_t div3(logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(Recip3);
        return chan_t'(p >> Recip3Shift);
    endfunction

    function automatic logic [15:0] sq_chan(chan_t a, chan_t b);
        chan_t d;
        d = (a >= b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    function automatic err_t sq_dist(rgb_t a, rgb_t b);
        return err_t'(sq_chan(a.r, b.r)) + err_t'(sq_chan(a.g, b.g))
             + err_t'(sq_chan(a.b, b.b));
    endfunction

endpackage

// ----- rtl/bc1e_if.sv -----
// ----------------------------------------------------------------------------
// bc1e interfaces
// valid/ready channels for pixels in and encoded blocks out
// ----------------------------------------------------------------------------
interface bc1e_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [bc1e_pkg::PixelW-1:0]   pixel_color;
    logic [bc1e_pkg::ColorW-1:0]   endpoint_zero;
    logic [bc1e_pkg::ColorW-1:0]   endpoint_one;

    modport source (output valid, pixel_color, endpoint_zero, endpoint_one, input ready);
    modport sink   (input valid, pixel_color, endpoint_zero, endpoint_one, output ready);
endinterface

interface bc1e_block_if;
    logic                          valid;
    logic                          ready;
    logic [bc1e_pkg::ColorW-1:0]   first_color;
    logic [bc1e_pkg::ColorW-1:0]   second_color;
    logic [bc1e_pkg::IndexW-1:0]   index_bits;

    modport source (output valid, first_color, second_color, index_bits, input ready);
    modport sink   (input valid, first_color, second_color, index_bits, output ready);
endinterface

// ----- rtl/bc1_block_index_encoder_core.sv -----
// throughput: one pixel transfer per cycle, one result per sixteen pixels
// the four pipeline stages advance together; they hold only while a finished
// result sits in the output register and is not taken
// reset (rst_n, async, active low) empties the pipeline, restarts the block
// at pixel zero and clears the held endpoints and the index accumulator
// ----------------------------------------------------------------------------
// bc1_block_index_encoder_core
// per-pixel bc1 palette index selection and 4x4 block packing
// ----------------------------------------------------------------------------
module bc1_block_index_encoder_core (
    input  logic             clk,
    input  logic             rst_n,
    bc1e_pixel_if.sink       pixel,
    bc1e_block_if.source     result
);

    // stage payloads
    typedef struct packed {
        bc1e_pkg::rgb_t      px;
        bc1e_pkg::color565_t c0;
        bc1e_pkg::color565_t c1;
        bc1e_pkg::pos_t      pos;
    } s1_t;

    typedef struct packed {
        bc1e_pkg::rgb_t      px;
        bc1e_pkg::palette_t  pal;
        logic                four;
        bc1e_pkg::color565_t c0;
        bc1e_pkg::color565_t c1;
        bc1e_pkg::pos_t      pos;
    } s2_t;

    typedef struct packed {
        bc1e_pkg::err_set_t  err;
        logic                four;
        bc1e_pkg::color565_t c0;
        bc1e_pkg::color565_t c1;
        bc1e_pkg::pos_t      pos;
    } s3_t;

    // whole pipeline moves unless a result is waiting and not taken
    logic advance;
    logic in_xfer;

    assign advance      = !(result.valid && !result.ready);
    assign pixel.ready  = advance;
    assign in_xfer      = pixel.valid && advance;

    // ------------------------------------------------------------------
    // input side: block position and endpoint latch
    // ------------------------------------------------------------------
    bc1e_pkg::pos_t      pos_reg;
    bc1e_pkg::color565_t held0_reg;
    bc1e_pkg::color565_t held1_reg;
    bc1e_pkg::color565_t c0_sel;
    bc1e_pkg::color565_t c1_sel;

    // first pixel of a block takes the endpoints straight from the channel
    assign c0_sel = (pos_reg == '0) ? pixel.endpoint_zero : held0_reg;
    assign c1_sel = (pos_reg == '0) ? pixel.endpoint_one  : held1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
        end
        else if (in_xfer)
        begin
            pos_reg   <= pos_reg + 1'b1;
            held0_reg <= c0_sel;
            held1_reg <= c1_sel;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: registered pixel and block endpoints
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;

    always_comb
    begin
        s1_next.px  = bc1e_pkg::rgb_t'(pixel.pixel_color);
        s1_next.c0  = c0_sel;
        s1_next.c1  = c1_sel;
        s1_next.pos = pos_reg;
    end

    // ------------------------------------------------------------------
    // stage 2: palette build
    // ------------------------------------------------------------------
    logic s2_valid_reg;
    s2_t  s2_reg;
    s2_t  s2_next;

    always_comb
    begin
        bc1e_pkg::rgb_t e0;
        bc1e_pkg::rgb_t e1;
        bc1e_pkg::rgb_t p2;
        bc1e_pkg::rgb_t p3;
        logic           four;

        e0   = bc1e_pkg::expand565(s1_reg.c0);
        e1   = bc1e_pkg::expand565(s1_reg.c1);
        // four-color mode when the second endpoint is below the first
        four = (s1_reg.c1 < s1_reg.c0);

        if (four)
        begin
            p2.r = bc1e_pkg::div3({1'b0, e0.r, 1'b0} + 10'(e1.r));
            p2.g = bc1e_pkg::div3({1'b0, e0.g, 1'b0} + 10'(e1.g));
            p2.b = bc1e_pkg::div3({1'b0, e0.b, 1'b0} + 10'(e1.b));
            p3.r = bc1e_pkg::div3(10'(e0.r) + {1'b0, e1.r, 1'b0});
            p3.g = bc1e_pkg::div3(10'(e0.g) + {1'b0, e1.g, 1'b0});
            p3.b = bc1e_pkg::div3(10'(e0.b) + {1'b0, e1.b, 1'b0});
        end
        else
        begin
            // rounded mean; the fourth entry is never picked
            p2.r = bc1e_pkg::chan_t'((9'(e0.r) + 9'(e1.r) + 9'd1) >> 1);
            p2.g = bc1e_pkg::chan_t'((9'(e0.g) + 9'(e1.g) + 9'd1) >> 1);
            p2.b = bc1e_pkg::chan_t'((9'(e0.b) + 9'(e1.b) + 9'd1) >> 1);
            p3   = '0;
        end

        s2_next.px     = s1_reg.px;
        s2_next.pal[0] = e0;
        s2_next.pal[1] = e1;
        s2_next.pal[2] = p2;
        s2_next.pal[3] = p3;
        s2_next.four   = four;
        s2_next.c0     = s1_reg.c0;
        s2_next.c1     = s1_reg.c1;
        s2_next.pos    = s1_reg.pos;
    end

    // ------------------------------------------------------------------
    // stage 3: squared rgb distance to each palette entry
    // ------------------------------------------------------------------
    logic s3_valid_reg;
    s3_t  s3_reg;
    s3_t  s3_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s3_next.err[k] = bc1e_pkg::sq_dist(s2_reg.px, s2_reg.pal[k]);
        end
        s3_next.four = s2_reg.four;
        s3_next.c0   = s2_reg.c0;
        s3_next.c1   = s2_reg.c1;
        s3_next.pos  = s2_reg.pos;
    end

    // ------------------------------------------------------------------
    // stage 4: pick least error, pack index, load result register
    // ------------------------------------------------------------------
    bc1e_pkg::idx_t              best_idx;
    logic [bc1e_pkg::IndexW-1:0] acc_reg;
    logic [bc1e_pkg::IndexW-1:0] acc_next;
    logic                        out_valid_reg;
    bc1e_pkg::color565_t         out_c0_reg;
    bc1e_pkg::color565_t         out_c1_reg;
    logic [bc1e_pkg::IndexW-1:0] out_idx_reg;
    logic                        block_end;

    // strict compare keeps the earliest index on ties
    always_comb
    begin
        bc1e_pkg::err_t best_err;

        best_idx = 2'd0;
        best_err = s3_reg.err[0];
        if (s3_reg.err[1] < best_err)
        begin
            best_idx = 2'd1;
            best_err = s3_reg.err[1];
        end
        if (s3_reg.err[2] < best_err)
        begin
            best_idx = 2'd2;
            best_err = s3_reg.err[2];
        end
        if (s3_reg.four && (s3_reg.err[3] < best_err))
        begin
            best_idx = 2'd3;
        end
    end

    // a new block starts from an empty word
    always_comb
    begin
        acc_next = (s3_reg.pos == '0) ? '0 : acc_reg;
        acc_next[{s3_reg.pos, 1'b0} +: 2] = best_idx;
    end

    assign block_end = s3_valid_reg && (s3_reg.pos == '1);

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pixel.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= block_end;
            if (s3_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            if (block_end)
            begin
                out_c0_reg  <= s3_reg.c0;
                out_c1_reg  <= s3_reg.c1;
                out_idx_reg <= acc_next;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.first_color  = out_c0_reg;
    assign result.second_color = out_c1_reg;
    assign result.index_bits   = out_idx_reg;

endmodule

// ----- rtl/bc1e_checker.sv -----
// ----------------------------------------------------------------------------
// bc1e_checker
// port-level checks on the bc1 index encoder, bound to the top level
// ----------------------------------------------------------------------------
module bc1e_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [bc1e_pkg::ColorW-1:0] first_color,
    input  logic [bc1e_pkg::ColorW-1:0] second_color,
    input  logic [bc1e_pkg::IndexW-1:0] index_bits
);

    bc1e_pkg::pos_t in_cnt_reg;
    logic [1:0]     pend_reg;
    logic           blk_done;
    logic           out_xfer;

    assign blk_done = in_valid && in_ready && (in_cnt_reg == '1);
    assign out_xfer = out_valid && out_ready;

    // blocks fully transferred in but not yet transferred out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_cnt_reg <= in_cnt_reg + 1'b1;
            end
            pend_reg <= pend_reg + 2'(blk_done) - 2'(out_xfer);
        end
    end

    // a result never appears without a complete block behind it
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without a complete block");

    // the encoder only backs up while a result waits
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // three-color blocks never use index three
    a_three_color_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (second_color >= first_color))
            |-> ((index_bits & (index_bits >> 1) & 32'h5555_5555) == 32'h0))
        else $error("index three in three-color block");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(first_color)
            && $stable(second_color) && $stable(index_bits)))
        else $error("result changed while stalled");

endmodule

bind bc1_block_index_encoder_core bc1e_checker u_bc1e_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixel.valid),
    .in_ready     (pixel.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .first_color  (result.first_color),
    .second_color (result.second_color),
    .index_bits   (result.index_bits)
);
